@@ rtl/core/timer_list_bank_defines.svh @@
// ----------------------------------------------------------------------------
// timer list bank assertion macros
// shared concurrent assertion forms, empty in synthesis builds
// ----------------------------------------------------------------------------
`ifndef TIMER_LIST_BANK_DEFINES_SVH
`define TIMER_LIST_BANK_DEFINES_SVH
`ifndef SYNTHESIS
// property checked every cycle outside reset
`define TLB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// consequent checked in the cycle after the antecedent
`define TLB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TLB_ASSERT(lbl, prop, msg)
`define TLB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/core/tlb_pkg.sv @@
// ----------------------------------------------------------------------------
// tlb_pkg
// types, codes and sizes shared by the timer list bank modules
// ----------------------------------------------------------------------------
`default_nettype none

package tlb_pkg;

	localparam int SLOTS   = 16;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	// op codes of the command field
	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_ADD    = 3'd1;
	localparam logic [2:0] OP_REMOVE = 3'd2;
	localparam logic [2:0] OP_STOP   = 3'd3;
	localparam logic [2:0] OP_RESUME = 3'd4;

	// status codes
	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_DUP_ADD    = 2'd1;
	localparam logic [1:0] STAT_NOT_LISTED = 2'd2;

	typedef logic [SLOT_W-1:0] idx_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [3:0]  slot;
		logic [63:0] start_count;
		logic [31:0] payload;
	} cmd_t;

	typedef struct packed {
		logic        fired;
		logic [3:0]  fired_slot;
		logic [31:0] fired_payload;
		logic [1:0]  status;
		logic        last;
	} rsp_t;

	typedef enum logic [2:0] {
		K_TICK,
		K_ADD,
		K_REMOVE,
		K_STOP,
		K_RESUME,
		K_NOP
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		idx_t        slot;
		logic [63:0] count;
		logic [31:0] payload;
	} q_ent_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FLUSH
	} state_t;

endpackage

`default_nettype wire

@@ rtl/core/tlb_front.sv @@
// ----------------------------------------------------------------------------
// tlb_front
// command intake: decodes each transaction and queues it for the engine
// ----------------------------------------------------------------------------
`default_nettype none
`include "timer_list_bank_defines.svh"

module tlb_front import tlb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  cmd_t   cmd,
	output logic   busy,
	input  logic   pop,
	output logic   avail,
	output q_ent_t head
);

	q_ent_t            fifo_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_ptr_q;
	logic [Q_AW-1:0]   rd_ptr_q;
	logic [Q_AW:0]     count_q;
	logic              push;
	logic              in_range;
	q_ent_t            ent;

	// decode op and range into a command kind
	always_comb begin
		in_range    = (32'(cmd.slot) < SLOTS);
		ent.slot    = idx_t'(cmd.slot);
		ent.count   = cmd.start_count;
		ent.payload = cmd.payload;
		ent.kind    = K_NOP;
		if (cmd.op == OP_TICK) begin
			ent.kind = K_TICK;
		end else if (in_range) begin
			unique case (cmd.op)
				OP_ADD:    ent.kind = K_ADD;
				OP_REMOVE: ent.kind = K_REMOVE;
				OP_STOP:   ent.kind = K_STOP;
				OP_RESUME: ent.kind = K_RESUME;
				default:   ent.kind = K_NOP;
			endcase
		end
	end

	assign busy  = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign push  = start & ~busy;
	assign avail = (count_q != '0);
	assign head  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`TLB_ASSERT(a_pop_nonempty, pop |-> (count_q != '0), "pop from empty queue")
	`TLB_ASSERT(a_count_bound, count_q <= (Q_AW+1)'(Q_DEPTH), "queue count overflow")
	`TLB_ASSERT_NEXT(a_count_inc, push && !pop, count_q == $past(count_q) + 1'b1, "queue count lost a push")

endmodule

`default_nettype wire

@@ rtl/core/tlb_back.sv @@
// ----------------------------------------------------------------------------
// tlb_back
// timer engine: list storage, op execution and the tick walk sequencer
// ----------------------------------------------------------------------------
`default_nettype none
`include "timer_list_bank_defines.svh"

module tlb_back import tlb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   avail,
	input  q_ent_t head,
	output logic   pop,
	output logic   rsp_valid,
	output rsp_t   rsp
);

	// timer storage, entries valid only once written
	logic [63:0]      remaining_q [SLOTS];
	logic [31:0]      payload_q   [SLOTS];
	idx_t             link_next_q [SLOTS];
	idx_t             link_prev_q [SLOTS];
	logic [SLOTS-1:0] running_q;
	logic [SLOTS-1:0] listed_q;
	idx_t             head_q;
	idx_t             tail_q;
	logic             empty_q;

	state_t           state_q, state_d;
	idx_t             cur_q, cur_d;
	idx_t             pred_q, pred_d;
	logic             pend_v_q, pend_v_d;
	logic             pend_we;
	idx_t             pend_slot_q;
	logic [31:0]      pend_pay_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	logic             rsp_we;
	rsp_t             rsp_d;

	idx_t             hs;
	logic [63:0]      dec;
	logic             hit;
	logic [1:0]       stat;

	logic             rem_we;
	idx_t             rem_wa;
	logic [63:0]      rem_wd;
	logic             pay_we;
	logic             run_we;
	idx_t             run_wa;
	logic             run_wd;
	logic             lst_we;
	idx_t             lst_wa;
	logic             lst_wd;
	logic             nxt_we;
	idx_t             nxt_wa;
	idx_t             nxt_wd;
	logic             prv_we;
	idx_t             prv_wa;
	idx_t             prv_wd;
	logic             head_we;
	idx_t             head_d;
	logic             tail_we;
	idx_t             tail_d;
	logic             empty_we;
	logic             empty_d;
	logic             unl_en;
	idx_t             unl_slot;
	idx_t             unl_pred;

	assign hs  = head.slot;
	assign dec = remaining_q[cur_q] - 64'd1;
	assign hit = running_q[cur_q] && (dec == 64'd0);

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		rsp_we   = 1'b0;
		rsp_d    = '0;
		stat     = STAT_OK;
		cur_d    = cur_q;
		pred_d   = pred_q;
		pend_v_d = pend_v_q;
		pend_we  = 1'b0;
		rem_we   = 1'b0;
		rem_wa   = cur_q;
		rem_wd   = dec;
		pay_we   = 1'b0;
		run_we   = 1'b0;
		run_wa   = hs;
		run_wd   = 1'b0;
		lst_we   = 1'b0;
		lst_wa   = hs;
		lst_wd   = 1'b0;
		nxt_we   = 1'b0;
		nxt_wa   = tail_q;
		nxt_wd   = hs;
		prv_we   = 1'b0;
		prv_wa   = hs;
		prv_wd   = tail_q;
		head_we  = 1'b0;
		head_d   = hs;
		tail_we  = 1'b0;
		tail_d   = hs;
		empty_we = 1'b0;
		empty_d  = 1'b0;
		unl_en   = 1'b0;
		unl_slot = hs;
		unl_pred = link_prev_q[hs];

		unique case (state_q)
			S_IDLE: begin
				if (avail) begin
					pop = 1'b1;
					unique case (head.kind)
						K_TICK: begin
							cur_d    = head_q;
							pend_v_d = 1'b0;
							state_d  = empty_q ? S_FLUSH : S_WALK;
						end
						K_ADD: begin
							if (listed_q[hs]) begin
								stat = STAT_DUP_ADD;
							end else begin
								rem_we  = 1'b1;
								rem_wa  = hs;
								rem_wd  = head.count;
								pay_we  = 1'b1;
								run_we  = 1'b1;
								run_wd  = 1'b1;
								lst_we  = 1'b1;
								lst_wd  = 1'b1;
								tail_we = 1'b1;
								if (empty_q) begin
									head_we  = 1'b1;
									empty_we = 1'b1;
									empty_d  = 1'b0;
								end else begin
									nxt_we = 1'b1;
									prv_we = 1'b1;
								end
							end
						end
						K_REMOVE: begin
							if (!listed_q[hs]) begin
								stat = STAT_NOT_LISTED;
							end else begin
								unl_en = 1'b1;
							end
						end
						K_STOP: begin
							run_we = 1'b1;
							run_wd = 1'b0;
						end
						K_RESUME: begin
							run_we = 1'b1;
							run_wd = 1'b1;
						end
						default: begin
						end
					endcase
					if (head.kind != K_TICK) begin
						rsp_we       = 1'b1;
						rsp_d.status = stat;
						rsp_d.last   = 1'b1;
					end
				end
			end
			S_WALK: begin
				if (running_q[cur_q]) begin
					rem_we = 1'b1;
				end
				if (hit) begin
					unl_en   = 1'b1;
					unl_slot = cur_q;
					unl_pred = pred_q;
					pend_we  = 1'b1;
					pend_v_d = 1'b1;
					if (pend_v_q) begin
						rsp_we              = 1'b1;
						rsp_d.fired         = 1'b1;
						rsp_d.fired_slot    = 4'(pend_slot_q);
						rsp_d.fired_payload = pend_pay_q;
					end
				end else begin
					pred_d = cur_q;
				end
				if (cur_q == tail_q) begin
					state_d = S_FLUSH;
				end else begin
					cur_d = link_next_q[cur_q];
				end
			end
			S_FLUSH: begin
				rsp_we     = 1'b1;
				rsp_d.last = 1'b1;
				if (pend_v_q) begin
					rsp_d.fired         = 1'b1;
					rsp_d.fired_slot    = 4'(pend_slot_q);
					rsp_d.fired_payload = pend_pay_q;
				end
				pend_v_d = 1'b0;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// unlink with a known predecessor
		if (unl_en) begin
			lst_we = 1'b1;
			lst_wa = unl_slot;
			lst_wd = 1'b0;
			if (head_q == unl_slot) begin
				if (tail_q == unl_slot) begin
					empty_we = 1'b1;
					empty_d  = 1'b1;
				end else begin
					head_we = 1'b1;
					head_d  = link_next_q[unl_slot];
				end
			end else begin
				nxt_we = 1'b1;
				nxt_wa = unl_pred;
				nxt_wd = link_next_q[unl_slot];
				if (tail_q == unl_slot) begin
					tail_we = 1'b1;
					tail_d  = unl_pred;
				end else begin
					prv_we = 1'b1;
					prv_wa = link_next_q[unl_slot];
					prv_wd = unl_pred;
				end
			end
		end
	end

	// storage and payload registers
	always_ff @(posedge clk) begin
		if (rem_we) begin
			remaining_q[rem_wa] <= rem_wd;
		end
		if (pay_we) begin
			payload_q[hs] <= head.payload;
		end
		if (nxt_we) begin
			link_next_q[nxt_wa] <= nxt_wd;
		end
		if (prv_we) begin
			link_prev_q[prv_wa] <= prv_wd;
		end
		if (pend_we) begin
			pend_slot_q <= cur_q;
			pend_pay_q  <= payload_q[cur_q];
		end
		cur_q  <= cur_d;
		pred_q <= pred_d;
		if (rsp_we) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= '0;
			listed_q    <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			empty_q     <= 1'b1;
			pend_v_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (run_we) begin
				running_q[run_wa] <= run_wd;
			end
			if (lst_we) begin
				listed_q[lst_wa] <= lst_wd;
			end
			if (head_we) begin
				head_q <= head_d;
			end
			if (tail_we) begin
				tail_q <= tail_d;
			end
			if (empty_we) begin
				empty_q <= empty_d;
			end
			pend_v_q    <= pend_v_d;
			rsp_valid_q <= rsp_we;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`TLB_ASSERT(a_ends_listed, !empty_q |-> (listed_q[head_q] && listed_q[tail_q]), "list end not listed")
	`TLB_ASSERT(a_empty_clear, empty_q |-> ($countones(listed_q) == 0), "listed slot in empty list")
	`TLB_ASSERT_NEXT(a_flush_last, state_q == S_FLUSH, rsp_valid && rsp.last, "tick without final result")

endmodule

`default_nettype wire

@@ rtl/core/timer_list_bank.sv @@
// ----------------------------------------------------------------------------
// timer_list_bank
// bank of one-shot countdown timers kept in an insertion-ordered list
// ----------------------------------------------------------------------------
// usage
// - command channel: a transaction is taken at a clock edge with start high
//   and busy low; cmd carries op, slot, start_count and payload
// - result channel: rsp_valid marks each result for exactly one cycle; the
//   receiver cannot hold results off, so results are never stalled or lost
// - commands enter a two-entry queue; busy rises only when the queue is full
// - add, remove, stop and resume each run in the idle state and give one result
// - a tick walks the list one slot per cycle from head to tail, then flushes;
//   no new command is taken from the queue until the tick is done
// - fired timers come out in list order, one per result; last marks the
//   final result of each command
// - a command is written into the queue, popped by the engine when idle, and
//   its result is registered before it appears on rsp
// - reset clears the queue, the running and listed flags and the list ends;
//   counts, payloads and links hold nothing until written by an add
// ----------------------------------------------------------------------------
`default_nettype none

module timer_list_bank import tlb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cmd_t cmd,
	output logic busy,
	output logic rsp_valid,
	output rsp_t rsp
);

	// queue handshake between intake and engine
	logic   pop;
	logic   avail;
	q_ent_t q_head;

	// intake: decode and queue commands
	tlb_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.pop    (pop),
		.avail  (avail),
		.head   (q_head)
	);

	// engine: list updates and tick walk, registered result
	tlb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (avail),
		.head      (q_head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_list_bank testbench
// drives add, remove, stop, resume, tick and invalid commands with random gaps
// or back to back, keeps its own copy of the timer list, checks each result in order
// ----------------------------------------------------------------------------

module testbench;
	import tlb_pkg::*;

	// op codes the block must ignore
	localparam logic [2:0] OP_BAD_FIRST = 3'd5;
	localparam logic [2:0] OP_BAD_LAST  = 3'd7;

	localparam int RANDOM_ITEMS = 300;
	localparam int MAX_GAP      = 18;
	// settle time, longer than a full tick walk over all SLOTS slots
	localparam int SETTLE_CYCLES = 2 * SLOTS + 8;
	// cycles without any transaction before the run is declared hung
	localparam int STALL_LIMIT  = 2000;

	// ------------------------------------------------------------------------
	// timer list tracker: mirrors the bank and queues the expected results
	// ------------------------------------------------------------------------
	class timer_scoreboard;
		logic [63:0] count_left [SLOTS];
		logic [31:0] pay_store  [SLOTS];
		bit          run_flag   [SLOTS];
		bit          in_list    [SLOTS];
		logic [3:0]  link       [SLOTS];
		logic [3:0]  head;
		logic [3:0]  tail;
		bit          empty;
		rsp_t        pending [$];
		int          errors;
		int          commands;
		int          results;
		int          expiries;
		int          deepest;

		function new();
			int i;
			for (i = 0; i < SLOTS; i++) begin
				count_left[i] = '0;
				pay_store[i]  = '0;
				run_flag[i]   = 1'b0;
				in_list[i]    = 1'b0;
				link[i]       = '0;
			end
			head     = '0;
			tail     = '0;
			empty    = 1'b1;
			errors   = 0;
			commands = 0;
			results  = 0;
			expiries = 0;
			deepest  = 0;
		endfunction

		// drop one slot from the chain, patching its predecessor
		function void unlink(logic [3:0] s);
			logic [3:0] p;
			int i;
			if (head == s) begin
				if (tail == s)
					empty = 1'b1;
				else
					head = link[s];
			end else begin
				p = head;
				for (i = 0; i < SLOTS; i++) begin
					if (link[p] == s) begin
						link[p] = link[s];
						if (tail == s)
							tail = p;
						break;
					end
					if (p == tail)
						break;
					p = link[p];
				end
			end
			in_list[s] = 1'b0;
		endfunction

		// one accepted command: update the list and queue what it gives
		function void note_command(cmd_t c);
			rsp_t       r;
			logic [1:0] stat;
			logic [3:0] cur;
			logic [3:0] nxt;
			bit         at_tail;
			logic [3:0] expired [$];
			int         i;
			int         depth;
			commands++;
			r = '0;
			if (c.op == OP_TICK) begin
				if (!empty) begin
					cur = head;
					for (i = 0; i < SLOTS; i++) begin
						nxt     = link[cur];
						at_tail = (cur == tail);
						if (run_flag[cur]) begin
							// zero wraps to all ones
							count_left[cur] = count_left[cur] - 64'd1;
							if (count_left[cur] == '0) begin
								unlink(cur);
								expired.push_back(cur);
							end
						end
						if (at_tail || empty)
							break;
						cur = nxt;
					end
				end
				if (expired.size() == 0) begin
					r.last = 1'b1;
					pending.push_back(r);
				end else begin
					for (i = 0; i < expired.size(); i++) begin
						r.fired         = 1'b1;
						r.fired_slot    = expired[i];
						r.fired_payload = pay_store[expired[i]];
						r.status        = STAT_OK;
						r.last          = (i == expired.size() - 1);
						pending.push_back(r);
					end
					expiries += expired.size();
				end
			end else begin
				stat = STAT_OK;
				case (c.op)
					OP_ADD: begin
						if (in_list[c.slot]) begin
							stat = STAT_DUP_ADD;
						end else begin
							count_left[c.slot] = c.start_count;
							pay_store[c.slot]  = c.payload;
							run_flag[c.slot]   = 1'b1;
							if (empty) begin
								head  = c.slot;
								empty = 1'b0;
							end else begin
								link[tail] = c.slot;
							end
							tail = c.slot;
							in_list[c.slot] = 1'b1;
						end
					end
					OP_REMOVE: begin
						if (!in_list[c.slot])
							stat = STAT_NOT_LISTED;
						else
							unlink(c.slot);
					end
					OP_STOP:   run_flag[c.slot] = 1'b0;
					OP_RESUME: run_flag[c.slot] = 1'b1;
					default: ;
				endcase
				r.status = stat;
				r.last   = 1'b1;
				pending.push_back(r);
			end
			depth = 0;
			for (i = 0; i < SLOTS; i++)
				depth += in_list[i];
			if (depth > deepest)
				deepest = depth;
		endfunction

		// one result off the bus against the oldest expectation
		function void check_result(rsp_t got);
			rsp_t want;
			results++;
			if (pending.size() == 0) begin
				$error("result with nothing expected: %h", got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.fired !== want.fired) begin
				$error("fired: expected %h, got %h", want.fired, got.fired);
				errors++;
			end
			if (got.fired_slot !== want.fired_slot) begin
				$error("fired_slot: expected %h, got %h", want.fired_slot, got.fired_slot);
				errors++;
			end
			if (got.fired_payload !== want.fired_payload) begin
				$error("fired_payload: expected %h, got %h",
					want.fired_payload, got.fired_payload);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %h, got %h", want.status, got.status);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %h, got %h", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// clock, reset and the block
	// ------------------------------------------------------------------------
	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	cmd_t cmd    = '0;
	logic busy;
	logic rsp_valid;
	rsp_t rsp;

	timer_scoreboard sb;
	bit dense = 1'b0;    // back-to-back commands when set
	int stall_cycles = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	timer_list_bank u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	// ------------------------------------------------------------------------
	// monitor: both channels sampled on the rising edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			// command transaction taken at this edge
			if (start && !busy)
				sb.note_command(cmd);
			// results cannot be held off, every strobe is a transaction
			if (rsp_valid)
				sb.check_result(rsp);
		end
	end

	// watchdog: hung when no transaction of either kind happens for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || rsp_valid)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d idle cycles", STALL_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// driver helpers
	// ------------------------------------------------------------------------
	function automatic cmd_t make_cmd(logic [2:0] op, logic [3:0] slot,
			logic [63:0] cnt, logic [31:0] pay);
		cmd_t c;
		c.op          = op;
		c.slot        = slot;
		c.start_count = cnt;
		c.payload     = pay;
		return c;
	endfunction

	// present one command after a random gap and hold it until taken;
	// start only goes low when a gap is actually drawn
	task automatic send_command(input cmd_t c);
		int gap;
		gap = dense ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		cmd   = c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	// a slot that is (or is not) in the list, random when there is none
	function automatic logic [3:0] pick_slot(bit want_listed);
		logic [3:0] cands [$];
		int i;
		for (i = 0; i < SLOTS; i++)
			if (sb.in_list[i] == want_listed)
				cands.push_back(i[3:0]);
		if (cands.size() == 0)
			return 4'($urandom_range(0, SLOTS - 1));
		return cands[$urandom_range(0, cands.size() - 1)];
	endfunction

	// one random command, biased toward sequences that make timers expire
	function automatic cmd_t random_cmd();
		int          roll;
		int          shape;
		logic [63:0] cnt;
		logic [31:0] pay;
		roll  = $urandom_range(0, 99);
		shape = $urandom_range(0, 99);
		pay   = $urandom;
		// mostly short counts so timers actually expire
		if (shape < 70)
			cnt = 64'($urandom_range(0, 6));
		else if (shape < 85)
			cnt = {$urandom, $urandom};
		else
			cnt = '1 - 64'($urandom_range(0, 3));
		if (roll < 30)
			return make_cmd(OP_TICK, 4'($urandom_range(0, SLOTS - 1)), cnt, pay);
		if (roll < 62)
			return make_cmd(OP_ADD, pick_slot($urandom_range(0, 9) == 0), cnt, pay);
		if (roll < 75)
			return make_cmd(OP_REMOVE, pick_slot($urandom_range(0, 5) != 0), cnt, pay);
		if (roll < 86)
			return make_cmd(OP_STOP, 4'($urandom_range(0, SLOTS - 1)), cnt, pay);
		if (roll < 97)
			return make_cmd(OP_RESUME, 4'($urandom_range(0, SLOTS - 1)), cnt, pay);
		return make_cmd(3'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST)),
			4'($urandom_range(0, SLOTS - 1)), cnt, pay);
	endfunction

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin
		int         i;
		logic [2:0] bad_op;
		sb = new();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part
		send_command(make_cmd(OP_TICK,   4'd0,  '0, '0));           // tick on empty list
		send_command(make_cmd(OP_ADD,    4'd0,  64'd1, '1));
		send_command(make_cmd(OP_ADD,    4'd15, '0, '0));           // zero count wraps
		send_command(make_cmd(OP_ADD,    4'd0,  '1, '1));           // add of a listed slot
		send_command(make_cmd(OP_TICK,   4'd0,  '0, '0));           // slot 0 expires
		send_command(make_cmd(OP_REMOVE, 4'd0,  '0, '0));           // remove of unlisted slot
		send_command(make_cmd(OP_STOP,   4'd3,  '0, '0));           // flag change while unlisted
		send_command(make_cmd(OP_RESUME, 4'd3,  '0, '0));
		send_command(make_cmd(OP_ADD,    4'd3,  64'd2, 32'hA5A5_A5A5));
		send_command(make_cmd(OP_STOP,   4'd3,  '0, '0));
		send_command(make_cmd(OP_ADD,    4'd7,  64'd1, 32'h5A5A_5A5A));
		send_command(make_cmd(OP_ADD,    4'd1,  64'd1, 32'h1234_5678));
		send_command(make_cmd(OP_TICK,   4'd0,  '0, '0));           // two expiries, stopped skipped
		send_command(make_cmd(OP_RESUME, 4'd3,  '0, '0));
		send_command(make_cmd(OP_TICK,   4'd0,  '0, '0));
		send_command(make_cmd(OP_TICK,   4'd0,  '0, '0));           // slot 3 expires
		send_command(make_cmd(OP_REMOVE, 4'd15, '0, '0));           // remove the head
		for (bad_op = OP_BAD_FIRST; bad_op <= OP_BAD_LAST && bad_op != 3'd0; bad_op++)
			send_command(make_cmd(bad_op, 4'd15, '1, '1));          // ignored op codes
		send_command(make_cmd(OP_ADD,    4'd15, '1, 32'h8000_0001));
		send_command(make_cmd(OP_STOP,   4'd15, '0, '0));
		send_command(make_cmd(OP_REMOVE, 4'd15, '0, '0));

		// random part, alternating stretches of gaps and back-to-back traffic
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 40 == 0)
				dense = ($urandom_range(0, 2) == 0);
			send_command(random_cmd());
		end
		start = 1'b0;

		// drain, then watch for stray results
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.pending.size() != 0) begin
			$error("%0d results never arrived", sb.pending.size());
			sb.errors++;
		end

		$display("ran %0d commands, checked %0d results including %0d timer expiries",
			sb.commands, sb.results, sb.expiries);
		$display("list reached %0d of %0d slots", sb.deepest, SLOTS);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/tlb_pkg.sv
rtl/core/tlb_front.sv
rtl/core/tlb_back.sv
rtl/core/timer_list_bank.sv
verif/testbench.sv
